/* src/assert_macros.svh */
// Assertion macros shared by the RTL files. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/wmb_pkg.sv */
// ----------------------------------------------------------------------------
// wmb_pkg: shared types and constants of the waveform min/max binner
// Register indexes, field widths and the structs that travel between the
// top level and the bin core.
// ----------------------------------------------------------------------------
`default_nettype none

package wmb_pkg;

  localparam int unsigned MaxBins   = 4096;
  localparam int unsigned FrameBits = 32;
  localparam int unsigned BinBits   = $clog2(MaxBins);
  localparam int unsigned CountBits = BinBits + 1;
  localparam int unsigned SampBits  = 16;

  typedef enum logic [1:0] {
    REG_BIN_COUNT    = 2'd0,
    REG_TOTAL_FRAMES = 2'd1,
    REG_SAMPLE_WIDTH = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  localparam logic [1:0] WidthByte = 2'd1;

  typedef struct packed {
    logic [CountBits-1:0] req_bins;
    logic [FrameBits-1:0] total_frames;
    logic [1:0]           sample_width;
  } wmb_cfg_t;

  typedef struct packed {
    logic                       close;
    logic                       last;
    logic [BinBits-1:0]         bin_index;
    logic signed [SampBits-1:0] bin_min;
    logic signed [SampBits-1:0] bin_max;
  } wmb_result_t;

endpackage

`default_nettype wire

/* src/wmb_bin_core.sv */
// ----------------------------------------------------------------------------
// wmb_bin_core: frame decode, bin tracking and running extremes
// Holds the lane state and updates it once per processed word. The result
// of each word is available combinationally in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wmb_bin_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         restart,
  input  wire logic                         proc,
  input  wire wmb_pkg::wmb_cfg_t            cfg,
  input  wire logic [7:0]                   sample_low,
  input  wire logic [7:0]                   sample_high,
  output wmb_pkg::wmb_result_t              res
);

  localparam int unsigned FB = wmb_pkg::FrameBits;
  localparam int unsigned CB = wmb_pkg::CountBits;
  localparam int unsigned BB = wmb_pkg::BinBits;
  localparam int unsigned SB = wmb_pkg::SampBits;
  localparam logic [CB-1:0] MaxCount = CB'(wmb_pkg::MaxBins);
  localparam logic signed [SB-1:0] MinInit = 16'sh7FFF;
  localparam logic signed [SB-1:0] MaxInit = 16'sh8000;

  logic [FB-1:0]          pos_r, pos_nxt;
  logic [BB-1:0]          bin_r, bin_nxt;
  logic [FB:0]            acc_r, acc_nxt;
  logic signed [SB-1:0]   min_r, min_nxt;
  logic signed [SB-1:0]   max_r, max_nxt;

  logic [FB-1:0]          n_eff;
  logic [CB-1:0]          b_clamp;
  logic [CB-1:0]          b_eff;
  logic signed [SB-1:0]   sample;
  logic signed [SB-1:0]   min_upd, max_upd;
  logic [FB:0]            acc_sum;
  logic                   last, close;

  always_comb begin
    n_eff = (cfg.total_frames == '0) ? FB'(1) : cfg.total_frames;
    priority if (cfg.req_bins == '0) begin
      b_clamp = CB'(1);
    end else if (cfg.req_bins > MaxCount) begin
      b_clamp = MaxCount;
    end else begin
      b_clamp = cfg.req_bins;
    end
    // The bin count never exceeds the frame count.
    b_eff = ({{(FB-CB){1'b0}}, b_clamp} > n_eff) ? n_eff[CB-1:0] : b_clamp;
  end

  // An 8-bit frame minus 128 is the byte with its top bit flipped.
  assign sample = (cfg.sample_width == wmb_pkg::WidthByte)
                ? {{8{~sample_low[7]}}, ~sample_low[7], sample_low[6:0]}
                : {sample_high, sample_low};

  assign min_upd = (sample < min_r) ? sample : min_r;
  assign max_upd = (sample > max_r) ? sample : max_r;
  assign acc_sum = acc_r + {{(FB+1-CB){1'b0}}, b_eff};
  assign last    = ({1'b0, pos_r} + (FB+1)'(1)) >= {1'b0, n_eff};
  assign close   = last || (acc_sum >= {1'b0, n_eff});

  always_comb begin
    res.close     = close;
    res.last      = last;
    res.bin_index = bin_r;
    res.bin_min   = min_upd;
    res.bin_max   = max_upd;
  end

  always_comb begin
    pos_nxt = pos_r;
    bin_nxt = bin_r;
    acc_nxt = acc_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (restart || (proc && last)) begin
      pos_nxt = '0;
      bin_nxt = '0;
      acc_nxt = '0;
      min_nxt = MinInit;
      max_nxt = MaxInit;
    end else if (proc) begin
      pos_nxt = pos_r + FB'(1);
      if (close) begin
        acc_nxt = acc_sum - {1'b0, n_eff};
        bin_nxt = bin_r + BB'(1);
        min_nxt = MinInit;
        max_nxt = MaxInit;
      end else begin
        acc_nxt = acc_sum;
        min_nxt = min_upd;
        max_nxt = max_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bin_r <= '0;
      acc_r <= '0;
      min_r <= MinInit;
      max_r <= MaxInit;
    end else begin
      pos_r <= pos_nxt;
      bin_r <= bin_nxt;
      acc_r <= acc_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  `ASSERT_ALWAYS(a_acc_below_n, acc_r < {1'b0, n_eff}, "accumulator reached frame count")
  `ASSERT_IMPLY(a_lane_start, pos_r == '0, (acc_r == '0) && (bin_r == '0), "lane start not clean")

endmodule

`default_nettype wire

/* src/waveform_minmax_binner.sv */
// An accepted word waits in the input register until the result slot is free; the result
// of a word that closes a bin is then registered in the result register.
// Throughput: one input word per cycle, sustained while the result side takes words.
// A word that closes no bin gives no result; each closed bin gives one word.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and starts a new lane; any configuration write starts one too.
// ----------------------------------------------------------------------------
// waveform_minmax_binner: min/max envelope decimation of a PCM lane
// Input register, bin core and result register; configuration by index.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module waveform_minmax_binner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // sample_low [7:0], sample_high [15:8]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // bin_index [11:0], bin_minimum [27:12],
                                       // bin_maximum [43:28], zero [47:44]
  output      logic        out_tlast   // final_bin
);

  localparam int unsigned CB = wmb_pkg::CountBits;
  localparam int unsigned FB = wmb_pkg::FrameBits;

  wmb_pkg::wmb_cfg_t    cfg_r, cfg_nxt;
  wmb_pkg::wmb_result_t res;
  wmb_pkg::reg_index_t  widx;

  logic        in_v_r, in_v_nxt;
  logic [15:0] in_d_r;
  logic        out_v_r, out_v_nxt;
  logic [47:0] out_d_r;
  logic        out_l_r;
  logic        cfg_we, proc;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign widx      = wmb_pkg::reg_index_t'(cfg_index);

  // A word leaves the input register when the result slot is free.
  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (widx)
        wmb_pkg::REG_BIN_COUNT:    cfg_nxt.req_bins     = cfg_data[CB-1:0];
        wmb_pkg::REG_TOTAL_FRAMES: cfg_nxt.total_frames = cfg_data[FB-1:0];
        wmb_pkg::REG_SAMPLE_WIDTH: cfg_nxt.sample_width = cfg_data[1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (proc) begin
      out_v_nxt = res.close;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.req_bins     <= CB'(1);
      cfg_r.total_frames <= FB'(1);
      cfg_r.sample_width <= 2'd2;
      in_v_r             <= 1'b0;
      out_v_r            <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_d_r <= in_tdata;
    end
    if (proc && res.close) begin
      out_d_r <= {4'b0, res.bin_max, res.bin_min, res.bin_index};
      out_l_r <= res.last;
    end
  end

  wmb_bin_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_we),
    .proc        (proc),
    .cfg         (cfg_r),
    .sample_low  (in_d_r[7:0]),
    .sample_high (in_d_r[15:8]),
    .res         (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

  `ASSERT_IMPLY(a_result_from_proc, $rose(out_v_r), $past(proc && res.close), "no closed bin")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the waveform min/max binner
// PCM frames are streamed through the block under several lane settings. A
// behavioral tracker predicts every closed bin, and each result word is
// compared with the oldest prediction while both stream sides stall at random, except in the last third of the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit  = 400000;
  localparam int FrameTarget = 1050;

  typedef struct packed {
    logic [11:0]        bin_index;
    logic signed [15:0] bin_minimum;
    logic signed [15:0] bin_maximum;
    logic               final_bin;
  } bin_result_t;

  // Tracks the lane position and open bin exactly as the block should.
  class envelope_tracker;
    logic [12:0]        req_bins;
    logic [31:0]        total_frames;
    logic [1:0]         sample_width;
    logic [31:0]        position;
    logic [11:0]        bin_idx;
    logic [32:0]        accum;
    logic signed [15:0] run_min;
    logic signed [15:0] run_max;
    bin_result_t        expected_bins[$];
    int                 mismatches;
    int                 bins_checked;
    int                 lanes_ended;

    function new();
      req_bins     = 13'd1;
      total_frames = 32'd1;
      sample_width = 2'd2;
      mismatches   = 0;
      bins_checked = 0;
      lanes_ended  = 0;
      restart_lane();
    endfunction

    function void restart_lane();
      position = '0;
      bin_idx  = '0;
      accum    = '0;
      run_min  = 16'sh7FFF;
      run_max  = 16'sh8000;
    endfunction

    // Any write starts a new lane, including one to the unused index.
    function void write_reg(input wmb_pkg::reg_index_t idx, input logic [31:0] data);
      case (idx)
        wmb_pkg::REG_BIN_COUNT:    req_bins = data[12:0];
        wmb_pkg::REG_TOTAL_FRAMES: total_frames = data;
        wmb_pkg::REG_SAMPLE_WIDTH: sample_width = data[1:0];
        default: ;
      endcase
      restart_lane();
    endfunction

    function void note_frame(input logic [7:0] lo, input logic [7:0] hi);
      logic [32:0]        n;
      logic [32:0]        b;
      logic signed [15:0] v;
      logic               at_end;
      logic               closing;
      bin_result_t        r;
      n = {1'b0, total_frames};
      if (n == 0) n = 33'd1;
      b = {20'd0, req_bins};
      if (b == 0) b = 33'd1;
      if (b > wmb_pkg::MaxBins) b = wmb_pkg::MaxBins;
      if (b > n) b = n;
      if (sample_width == wmb_pkg::WidthByte) v = {8'h00, lo} - 16'd128;
      else v = {hi, lo};
      if (v < run_min) run_min = v;
      if (v > run_max) run_max = v;
      at_end  = ({1'b0, position} + 33'd1) >= n;
      accum   = accum + b;
      closing = at_end || (accum >= n);
      if (closing) begin
        r.bin_index   = bin_idx;
        r.bin_minimum = run_min;
        r.bin_maximum = run_max;
        r.final_bin   = at_end;
        expected_bins.insert(expected_bins.size(), r);
      end
      if (at_end) begin
        restart_lane();
      end else begin
        position = position + 32'd1;
        if (closing) begin
          accum   = accum - n;
          bin_idx = bin_idx + 12'd1;
          run_min = 16'sh7FFF;
          run_max = 16'sh8000;
        end
      end
    endfunction

    function void check_bin(input logic [47:0] data, input logic tlast);
      bin_result_t want;
      bins_checked++;
      if (tlast) lanes_ended++;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected bin word index %0d min %0d max %0d last %0b",
                   data[11:0], $signed(data[27:12]), $signed(data[43:28]), tlast);
        return;
      end
      want = expected_bins.pop_front();
      if (data[11:0] !== want.bin_index || data[27:12] !== want.bin_minimum ||
          data[43:28] !== want.bin_maximum || tlast !== want.final_bin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: bin word expected idx %0d min %0d max %0d last %0b",
                   want.bin_index, want.bin_minimum, want.bin_maximum, want.final_bin);
          $display("       got idx %0d min %0d max %0d last %0b",
                   data[11:0], $signed(data[27:12]), $signed(data[43:28]), tlast);
        end
      end
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = wmb_pkg::REG_BIN_COUNT;
  logic [31:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // sample_low [7:0], sample_high [15:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // bin_index [11:0], bin_minimum [27:12],
                                  // bin_maximum [43:28], zero [47:44]
  logic        out_tlast;         // final_bin

  envelope_tracker tracker = new();
  int send_idle_pct  = 9;
  int recv_stall_pct = 73;
  int frames_sent    = 0;
  int lane_settings  = 0;
  int cycles         = 0;

  waveform_minmax_binner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_bin(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Leaves in_tvalid high; the caller lowers it in the same step when the
  // stream pauses, so the next word can follow without a gap.
  task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_frame(lo, hi);
    frames_sent++;
  endtask

  // A frame that closes no bin can still sit in the pipe when the queue runs
  // dry, so settle keeps waiting after the queue is empty, before the next register write.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input wmb_pkg::reg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  initial begin
    int          lane;
    int          len;
    int          pick;
    bit          wrote;
    logic [31:0] bc;
    logic [31:0] tf;
    logic [1:0]  sw;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: every frame is a one-frame lane with a single bin.
    send_frame(8'h00, 8'h00);
    send_frame(8'hFF, 8'h7F);
    send_frame(8'h00, 8'h80);
    send_frame(8'hFF, 8'hFF);

    // 8-bit samples with zero bin count and zero frame count.
    settle();
    write_reg(wmb_pkg::REG_SAMPLE_WIDTH, 32'd1);
    write_reg(wmb_pkg::REG_TOTAL_FRAMES, 32'd0);
    write_reg(wmb_pkg::REG_BIN_COUNT, 32'd0);
    cfg_valid <= 1'b0;
    lane_settings++;
    send_frame(8'h00, 8'hA5);
    send_frame(8'hFF, 8'h5A);
    send_frame(8'h80, 8'hFF);

    // Odd width code decodes as 16-bit; oversized bin count saturates, then
    // clips to the frame count.
    settle();
    write_reg(wmb_pkg::REG_SAMPLE_WIDTH, 32'd3);
    write_reg(wmb_pkg::REG_TOTAL_FRAMES, 32'd6);
    write_reg(wmb_pkg::REG_BIN_COUNT, 32'd8191);
    cfg_valid <= 1'b0;
    lane_settings++;
    send_frame(8'h00, 8'h80);
    send_frame(8'hFF, 8'h7F);
    send_frame(8'h01, 8'h00);
    send_frame(8'hFF, 8'hFF);
    send_frame(8'h00, 8'h00);
    send_frame(8'h34, 8'h12);

    // Width code zero; a lane cut short, restarted by an unused-index write.
    settle();
    write_reg(wmb_pkg::REG_SAMPLE_WIDTH, 32'd0);
    write_reg(wmb_pkg::REG_TOTAL_FRAMES, 32'd5);
    write_reg(wmb_pkg::REG_BIN_COUNT, 32'd2);
    cfg_valid <= 1'b0;
    lane_settings++;
    repeat (3) send_frame(pick_byte(), pick_byte());
    settle();
    write_reg(wmb_pkg::REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    repeat (5) send_frame(pick_byte(), pick_byte());

    // Largest frame count with the full bin count: no bin closes this soon.
    settle();
    write_reg(wmb_pkg::REG_TOTAL_FRAMES, 32'hFFFF_FFFF);
    write_reg(wmb_pkg::REG_BIN_COUNT, 32'hFFFF_F000);
    cfg_valid <= 1'b0;
    lane_settings++;
    repeat (4) send_frame(pick_byte(), pick_byte());

    while (frames_sent < FrameTarget) begin
      if (frames_sent < FrameTarget / 3) begin
        send_idle_pct  = 9;
        recv_stall_pct = 73;
      end else if (frames_sent < 2 * FrameTarget / 3) begin
        send_idle_pct  = 73;
        recv_stall_pct = 9;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      pick = $urandom_range(99);
      if (pick < 60) tf = $urandom_range(1, 24);
      else if (pick < 90) tf = $urandom_range(25, 120);
      else if (pick < 95) tf = $urandom_range(121, 300);
      else tf = $urandom();

      pick = $urandom_range(99);
      if (pick < 10) bc = 32'd0;
      else if (pick < 20) bc = $urandom_range(4097, 8191);
      else if (pick < 30) bc = $urandom();
      else bc = $urandom_range(1, (tf > 300) ? 4096 : tf + 2);

      pick = $urandom_range(99);
      if (pick < 40) sw = 2'd1;
      else if (pick < 80) sw = 2'd2;
      else sw = 2'($urandom_range(3));

      settle();
      wrote = 1'b0;
      if ($urandom_range(2) != 0) begin
        write_reg(wmb_pkg::REG_BIN_COUNT, bc);
        wrote = 1'b1;
      end
      if ($urandom_range(2) != 0) begin
        write_reg(wmb_pkg::REG_TOTAL_FRAMES, tf);
        wrote = 1'b1;
      end
      if ($urandom_range(2) != 0 || !wrote) begin
        write_reg(wmb_pkg::REG_SAMPLE_WIDTH, ($urandom() & 32'hFFFF_FFFC) | sw);
      end
      if ($urandom_range(7) == 0) write_reg(wmb_pkg::REG_UNUSED, $urandom());
      cfg_valid <= 1'b0;
      lane_settings++;

      // Mostly whole lanes; now and then a lane is left unfinished.
      lane = (tracker.total_frames == 0) ? 1 : tracker.total_frames;
      if (tracker.total_frames > 400) begin
        len = $urandom_range(10, 40);
      end else begin
        len = lane * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) len = len + $urandom_range(0, lane - 1);
      end
      // The run stops close to the frame target.
      if (len > FrameTarget - frames_sent) len = FrameTarget - frames_sent;
      repeat (len) send_frame(pick_byte(), pick_byte());
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d frames under %0d lane settings; %0d bin words checked, %0d ending a lane",
             frames_sent, lane_settings, tracker.bins_checked, tracker.lanes_ended);
    $display("8/16-bit decoding, zero and saturated bin counts, zero and full frame counts");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
